// ----- src/bbr_pkg.sv -----
// Shared types and constants for the burst backoff reconnect controller.
`default_nettype none
package bbr_pkg;

	localparam int unsigned TIME_W   = 32;
	localparam int unsigned BASE_W   = 24;
	localparam int unsigned CNT_W    = 8;
	localparam int unsigned MAX_SHIFT = 4;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DAT_W = 32;
	localparam int unsigned IN_DATA_W  = 40;
	localparam int unsigned OUT_DATA_W = 48;

	typedef enum logic [2:0] {
		MODE_OFF        = 3'd0,
		MODE_DISC       = 3'd1,
		MODE_CONNECTING = 3'd2,
		MODE_CONNECTED  = 3'd3,
		MODE_BACKOFF    = 3'd4
	} mode_t;

	localparam logic [1:0] CMD_POLL  = 2'd0;
	localparam logic [1:0] CMD_START = 2'd1;
	localparam logic [1:0] CMD_FORCE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_BURST_LIMIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_MS     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_MS      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ENABLED     = 2'd3;

	localparam logic [CNT_W-1:0]  RST_BURST_LIMIT = 8'd5;
	localparam logic [BASE_W-1:0] RST_BASE_MS     = 24'd5000;
	localparam logic [TIME_W-1:0] RST_MAX_MS      = 32'd60000;
	localparam logic [CNT_W-1:0]  LEVEL_MAX       = 8'd255;

	typedef struct packed {
		logic [CNT_W-1:0]  burst_limit;
		logic [BASE_W-1:0] base_ms;
		logic [TIME_W-1:0] max_ms;
		logic              enabled;
	} cfg_t;

	typedef struct packed {
		logic [1:0]        command;
		logic [TIME_W-1:0] now_ms;
		logic              link_up;
		logic              connect_ok;
		logic              server_present;
	} item_t;

	typedef struct packed {
		logic [2:0]        mode_code;
		logic              attempt_now;
		logic              service_link;
		logic              link_lost;
		logic [CNT_W-1:0]  attempt_number;
		logic [TIME_W-1:0] backoff_duration;
	} res_t;

	typedef struct packed {
		mode_t             mode;
		logic [CNT_W-1:0]  attempt_count;
		logic [CNT_W-1:0]  backoff_level;
		logic [TIME_W-1:0] last_time;
		logic              last_valid;
		logic [TIME_W-1:0] backoff_length;
	} state_t;

endpackage
`default_nettype wire

// ----- src/bbr_cfg.sv -----
// Configuration register file of the reconnect controller.
`default_nettype none
module bbr_cfg (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              wr_en,
	input  wire [bbr_pkg::CFG_IDX_W-1:0]     wr_index,
	input  wire [bbr_pkg::CFG_DAT_W-1:0]     wr_data,
	output bbr_pkg::cfg_t                    cfg
);
	import bbr_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.burst_limit <= RST_BURST_LIMIT;
			cfg_q.base_ms     <= RST_BASE_MS;
			cfg_q.max_ms      <= RST_MAX_MS;
			cfg_q.enabled     <= 1'b0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_BURST_LIMIT: cfg_q.burst_limit <= wr_data[CNT_W-1:0];
				REG_BASE_MS:     cfg_q.base_ms     <= wr_data[BASE_W-1:0];
				REG_MAX_MS:      cfg_q.max_ms      <= wr_data[TIME_W-1:0];
				REG_ENABLED:     cfg_q.enabled     <= wr_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// ----- src/bbr_core.sv -----
// Controller state registers and the single-step next-state and result logic.
`default_nettype none
module bbr_core (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            step,
	input  bbr_pkg::cfg_t  cfg,
	input  bbr_pkg::item_t item,
	output bbr_pkg::res_t  res
);
	import bbr_pkg::*;

	state_t cur_q;
	state_t nxt;

	logic [TIME_W-1:0] base_ext;
	logic [TIME_W-1:0] elapsed;
	logic              too_soon;
	logic              burst_done;
	logic              backoff_over;
	logic [CNT_W-1:0]  level_inc;
	logic [CNT_W-1:0]  level_m1;
	logic [3:0]        shamt;
	logic [TIME_W-1:0] len_raw;
	logic [TIME_W-1:0] len_cap;
	logic              attempt;
	logic              service;
	logic              lost;

	assign base_ext     = {{(TIME_W-BASE_W){1'b0}}, cfg.base_ms};
	assign elapsed      = item.now_ms - cur_q.last_time;
	assign too_soon     = cur_q.last_valid && (elapsed < base_ext);
	assign burst_done   = cur_q.attempt_count >= cfg.burst_limit;
	assign backoff_over = elapsed >= cur_q.backoff_length;

	// The level saturates; the shift uses the new level minus one, capped.
	assign level_inc = (cur_q.backoff_level == LEVEL_MAX) ? cur_q.backoff_level
	                                                      : cur_q.backoff_level + 8'd1;
	assign level_m1  = level_inc - 8'd1;
	assign shamt     = (level_m1 > CNT_W'(MAX_SHIFT)) ? 4'(MAX_SHIFT) : level_m1[3:0];
	assign len_raw   = base_ext << shamt;
	assign len_cap   = (len_raw > cfg.max_ms) ? cfg.max_ms : len_raw;

	always_comb begin
		nxt = cur_q;
		unique case (item.command)
			CMD_START: begin
				if (item.server_present) begin
					nxt.mode           = MODE_CONNECTING;
					nxt.attempt_count  = '0;
					nxt.backoff_level  = '0;
					nxt.backoff_length = base_ext;
					nxt.last_time      = '0;
					nxt.last_valid     = 1'b0;
				end else begin
					nxt.mode = MODE_OFF;
				end
			end
			CMD_FORCE: begin
				if (cfg.enabled) begin
					nxt.mode           = MODE_CONNECTING;
					nxt.attempt_count  = '0;
					nxt.backoff_level  = '0;
					nxt.backoff_length = base_ext;
					nxt.last_time      = '0;
					nxt.last_valid     = 1'b0;
				end
			end
			CMD_POLL: begin
				unique case (cur_q.mode)
					MODE_CONNECTING: begin
						priority if (item.link_up) begin
							nxt.mode = MODE_CONNECTED;
						end else if (burst_done) begin
							nxt.backoff_level  = level_inc;
							nxt.backoff_length = len_cap;
							nxt.last_time      = item.now_ms;
							nxt.last_valid     = 1'b1;
							nxt.attempt_count  = '0;
							nxt.mode           = MODE_BACKOFF;
						end else if (!too_soon) begin
							nxt.last_time  = item.now_ms;
							nxt.last_valid = 1'b1;
							if (item.connect_ok) begin
								nxt.mode           = MODE_CONNECTED;
								nxt.attempt_count  = '0;
								nxt.backoff_level  = '0;
								nxt.backoff_length = base_ext;
							end else begin
								nxt.attempt_count = cur_q.attempt_count + 8'd1;
							end
						end
					end
					MODE_CONNECTED: begin
						if (!item.link_up) begin
							nxt.attempt_count = '0;
							nxt.last_time     = '0;
							nxt.last_valid    = 1'b0;
							nxt.mode          = MODE_CONNECTING;
						end
					end
					MODE_BACKOFF: begin
						if (backoff_over) begin
							nxt.attempt_count = '0;
							nxt.last_time     = '0;
							nxt.last_valid    = 1'b0;
							nxt.mode          = MODE_CONNECTING;
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	always_comb begin
		attempt = 1'b0;
		service = 1'b0;
		lost    = 1'b0;
		if (item.command == CMD_POLL) begin
			unique case (cur_q.mode)
				MODE_CONNECTING: attempt = !item.link_up && !burst_done && !too_soon;
				MODE_CONNECTED: begin
					service = item.link_up;
					lost    = !item.link_up;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q.mode           <= MODE_OFF;
			cur_q.attempt_count  <= '0;
			cur_q.backoff_level  <= '0;
			cur_q.last_time      <= '0;
			cur_q.last_valid     <= 1'b0;
			cur_q.backoff_length <= {{(TIME_W-BASE_W){1'b0}}, RST_BASE_MS};
		end else if (step) begin
			cur_q <= nxt;
		end
	end

	assign res.mode_code        = nxt.mode;
	assign res.attempt_now      = attempt;
	assign res.service_link     = service;
	assign res.link_lost        = lost;
	assign res.attempt_number   = nxt.attempt_count;
	assign res.backoff_duration = nxt.backoff_length;

endmodule
`default_nettype wire

// ----- src/burst_backoff_reconnect_fsm.sv -----
// Top level of the link reconnect controller with burst attempts and backoff.
//
// Channel   Dir  Handshake            Payload
// s_*       in   s_tvalid/s_tready    s_tuser = command, s_tdata = time and link flags
// m_*       out  m_tvalid/m_tready    m_tdata = mode, strobes, count, backoff length
// cfg_*     in   cfg_valid/cfg_ready  cfg_index selects the register, cfg_data value
//
// An input beat is captured in an input register and, once the output register is
// free or is being emptied, processed as its result is loaded into the output register;
// one beat can be accepted every cycle while the output side does not stall.
// The throughput limit is the single controller state update per cycle.
// A stall on the output side holds the result register; the input register then
// keeps its beat and s_tready drops only when both registers are full.
// Reset clears mode, counters and attempt record and loads the default registers.
`default_nettype none
module burst_backoff_reconnect_fsm (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                s_tvalid,
	output logic                               s_tready,
	// [31:0] now_ms, [32] link_up, [33] connect_ok, [34] server_present, rest zero
	input  wire [bbr_pkg::IN_DATA_W-1:0]       s_tdata,
	// [1:0] command
	input  wire [1:0]                          s_tuser,
	output logic                               m_tvalid,
	input  wire                                m_tready,
	// [2:0] mode_code, [3] attempt_now, [4] service_link, [5] link_lost,
	// [13:6] attempt_number, [45:14] backoff_duration, rest zero
	output logic [bbr_pkg::OUT_DATA_W-1:0]     m_tdata,
	input  wire                                cfg_valid,
	output logic                               cfg_ready,
	input  wire [bbr_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire [bbr_pkg::CFG_DAT_W-1:0]       cfg_data
);
	import bbr_pkg::*;

	cfg_t  cfg;
	item_t item_s1;
	logic  valid_s1;
	logic  advance;
	res_t  res;
	res_t  res_q;
	logic  out_valid_q;

	// Registers can always be written; the user must write only while the block is idle (not enforced).
	assign cfg_ready = 1'b1;

	bbr_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// The beat in the input register moves on when the output register is free
	// or is being emptied in the same cycle.
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.command        <= s_tuser;
			item_s1.now_ms         <= s_tdata[TIME_W-1:0];
			item_s1.link_up        <= s_tdata[TIME_W];
			item_s1.connect_ok     <= s_tdata[TIME_W+1];
			item_s1.server_present <= s_tdata[TIME_W+2];
		end
	end

	// The controller state steps exactly once per beat, as its result is loaded into the output register.
	bbr_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.cfg    (cfg),
		.item   (item_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, res_q.backoff_duration, res_q.attempt_number,
	                   res_q.link_lost, res_q.service_link, res_q.attempt_now,
	                   res_q.mode_code};

	// An attempt is only reported while connecting or just after success.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && res_q.attempt_now) |->
		(res_q.mode_code == MODE_CONNECTING || res_q.mode_code == MODE_CONNECTED))
		else $error("attempt reported outside connecting or connected mode");

	// Servicing the link requires the connected mode.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && res_q.service_link) |->
		(res_q.mode_code == MODE_CONNECTED && !res_q.link_lost))
		else $error("service strobe without connected mode");

	// A dropped link goes back to connecting with a fresh burst count.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && res_q.link_lost) |->
		(res_q.mode_code == MODE_CONNECTING && res_q.attempt_number == '0))
		else $error("link loss did not restart the burst");

	// A waiting beat in the input register is never dropped while stalled.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(item_s1)))
		else $error("stalled input beat was lost");

endmodule
`default_nettype wire
